/* sv/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants of the delta-list timer queue: request and
// result structs, function and result codes, controller states and the
// link and command structs of the cell chain.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int HANDLE_W    = 8;
  localparam int DELTA_W     = 32;
  localparam int TICKS_W     = 8;
  localparam int MS_W        = 10;
  localparam int KIND_W      = 2;
  // ticks times the tick scale fits in the sum of both widths
  localparam int TIME_W      = TICKS_W + MS_W;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [MS_W-1:0] TICK_SCALE_RESET = MS_W'(64);

  // function codes of a request
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  // register word index
  localparam logic REG_TICK_SCALE = 1'b0;

  typedef struct packed {
    logic                func;
    logic [HANDLE_W-1:0] handle;
    logic [DELTA_W-1:0]  wait_ms;
    logic [TICKS_W-1:0]  elapsed_ticks;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] expired_handle;
    logic                last;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TICK,
    ST_FIX,
    ST_RESP
  } state_e;

  // what one cell shows its neighbours
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DELTA_W-1:0]  delta;
    logic [DELTA_W-1:0]  rem;    // search remainder held by this cell
    logic                pass;   // search token moves on to the next cell
    logic                hit;    // new entry goes into this cell
  } cell_link_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic                hit_any;
    logic                pop;
    logic                fix;
    logic [DELTA_W-1:0]  fix_delta;
    logic [HANDLE_W-1:0] new_handle;
  } cell_cmd_t;

endpackage

/* sv/delta_list_timer_queue.sv */
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Software timer queue kept as a sorted delta list in a chain of cells.
// ----------------------------------------------------------------------------
// An add request walks a search token down the cell chain, one cell per
// cycle, and inserts in the cycle the token stops; its single result is
// then loaded from the response state, and the block goes back to idle.
// A tick request pops one expired head per cycle from cell 0 while the
// output register is free, offering one result per pop; it then passes
// the fix state, where leftover time comes off the new head, and returns
// to idle. A tick with no expiry passes the fix state and then offers a
// single none result. A full-queue add is answered with a rejected
// result. Each result waits for the output register to be free.
// One request is worked on at a time; the next is taken once the block is
// back in idle, while the last result may still wait in the output
// register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dltq_pkg::in_req_t  in_req_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dltq_pkg::out_res_t out_res_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  dltq_pkg::state_e                state_q, state_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [dltq_pkg::MS_W-1:0]       ms_q;
  logic [dltq_pkg::TIME_W-1:0]     rem_q, rem_d;
  logic [dltq_pkg::NRES_W-1:0]     nres_q, nres_d;
  logic [dltq_pkg::HANDLE_W-1:0]   handle_q, handle_d;
  logic [dltq_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic                            out_valid_q, out_valid_d;
  dltq_pkg::out_res_t              out_q, out_d;

  dltq_pkg::cell_cmd_t             cmd;
  dltq_pkg::cell_link_t            head_in;
  dltq_pkg::cell_link_t            links  [DEPTH];
  dltq_pkg::cell_link_t            prev_l [DEPTH];
  dltq_pkg::cell_link_t            next_l [DEPTH];
  logic [DEPTH-1:0]                hits;

  logic                            in_fire;
  logic                            out_free;
  logic                            cfg_wr;
  logic [dltq_pkg::DELTA_W-1:0]    rem_ext;
  logic [dltq_pkg::TIME_W-1:0]     rem_after;
  logic                            due;
  logic                            due_next;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dltq_pkg::REG_TICK_SCALE);
  assign prdata = (paddr[2] == dltq_pkg::REG_TICK_SCALE) ?
                  {{(32 - dltq_pkg::MS_W){1'b0}}, ms_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= dltq_pkg::TICK_SCALE_RESET;
    end else if (cfg_wr) begin
      ms_q <= pwdata[dltq_pkg::MS_W-1:0];
    end
  end

  // cell chain
  assign head_in.handle = '0;
  assign head_in.delta  = '0;
  assign head_in.rem    = in_req_i.wait_ms;
  assign head_in.pass   = in_fire && (in_req_i.func == dltq_pkg::FUNC_ADD) &&
                          (count_q != CNT_W'(DEPTH));
  assign head_in.hit    = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_l[k] = head_in;
    end else begin : g_mid
      assign prev_l[k] = links[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_l[k] = '0;
    end else begin : g_body
      assign next_l[k] = links[k+1];
    end
    assign hits[k] = links[k].hit;

    dltq_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .cmd_i   (cmd),
      .prev_i  (prev_l[k]),
      .next_i  (next_l[k]),
      .link_o  (links[k])
    );
  end

  // head checks for expiry
  assign rem_ext   = dltq_pkg::DELTA_W'(rem_q);
  assign due       = (count_q != '0) && (links[0].delta <= rem_ext) &&
                     (nres_q < dltq_pkg::NRES_W'(dltq_pkg::MAX_RESULTS));
  assign rem_after = rem_q - links[0].delta[dltq_pkg::TIME_W-1:0];
  assign due_next  = (count_q > CNT_W'(1)) &&
                     (links[1].delta <= dltq_pkg::DELTA_W'(rem_after)) &&
                     (nres_q < dltq_pkg::NRES_W'(dltq_pkg::MAX_RESULTS - 1));

  assign in_ready_o = (state_q == dltq_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // controller: next state, cell commands and result loading
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    nres_d      = nres_q;
    handle_d    = handle_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    cmd.hit_any    = |hits;
    cmd.pop        = 1'b0;
    cmd.fix        = 1'b0;
    cmd.fix_delta  = (links[0].delta <= rem_ext) ? '0 : (links[0].delta - rem_ext);
    cmd.new_handle = handle_q;

    case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (in_fire) begin
          handle_d = in_req_i.handle;
          if (in_req_i.func == dltq_pkg::FUNC_TICK) begin
            rem_d   = dltq_pkg::TIME_W'(in_req_i.elapsed_ticks) * dltq_pkg::TIME_W'(ms_q);
            nres_d  = '0;
            state_d = dltq_pkg::ST_TICK;
          end else if (count_q == CNT_W'(DEPTH)) begin
            kind_d  = dltq_pkg::KIND_REJECTED;
            state_d = dltq_pkg::ST_RESP;
          end else begin
            state_d = dltq_pkg::ST_WALK;
          end
        end
      end
      dltq_pkg::ST_WALK: begin
        if (cmd.hit_any) begin
          count_d = count_q + CNT_W'(1);
          kind_d  = dltq_pkg::KIND_ADDED;
          state_d = dltq_pkg::ST_RESP;
        end
      end
      dltq_pkg::ST_TICK: begin
        if (!due) begin
          state_d = dltq_pkg::ST_FIX;
        end else if (out_free) begin
          cmd.pop              = 1'b1;
          count_d              = count_q - CNT_W'(1);
          rem_d                = rem_after;
          nres_d               = nres_q + dltq_pkg::NRES_W'(1);
          out_valid_d          = 1'b1;
          out_d.kind           = dltq_pkg::KIND_EXPIRED;
          out_d.expired_handle = links[0].handle;
          out_d.last           = !due_next;
          if (!due_next) begin
            state_d = dltq_pkg::ST_FIX;
          end
        end
      end
      dltq_pkg::ST_FIX: begin
        // leftover time comes off the new head
        cmd.fix = (count_q != '0);
        if (nres_q == '0) begin
          kind_d   = dltq_pkg::KIND_NONE;
          handle_d = '0;
          state_d  = dltq_pkg::ST_RESP;
        end else begin
          state_d = dltq_pkg::ST_IDLE;
        end
      end
      dltq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.kind           = kind_q;
          out_d.expired_handle = handle_q;
          out_d.last           = 1'b1;
          state_d              = dltq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dltq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dltq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    nres_q   <= nres_d;
    handle_q <= handle_d;
    kind_q   <= kind_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // checks
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hits))
    else $error("more than one cell took the new entry");

  a_walk_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dltq_pkg::ST_WALK) |-> (count_q < CNT_W'(DEPTH)))
    else $error("insertion search on a full queue");

  a_hit_only_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|hits) |-> (state_q == dltq_pkg::ST_WALK))
    else $error("insertion outside the search");

endmodule

/* sv/dltq_cell.sv */
// ----------------------------------------------------------------------------
// dltq_cell
// One slot of the delta list. Holds a handle and a delta, takes part in the
// insertion search by passing a remainder token down the chain, and shifts
// its entry down on insert or up on a head pop.
// ----------------------------------------------------------------------------
module dltq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CNT_W-1:0]      count_i,
  input  dltq_pkg::cell_cmd_t   cmd_i,
  input  dltq_pkg::cell_link_t  prev_i,
  input  dltq_pkg::cell_link_t  next_i,
  output dltq_pkg::cell_link_t  link_o
);

  logic [dltq_pkg::HANDLE_W-1:0] handle_q, handle_d;
  logic [dltq_pkg::DELTA_W-1:0]  delta_q, delta_d;
  logic [dltq_pkg::DELTA_W-1:0]  rem_q, rem_d;
  logic                          tok_q, tok_d;
  logic                          passed_q, passed_d;
  logic                          live;
  logic                          hit;
  logic                          pass;

  // search: stop here if the slot is empty or the new wait ends first
  assign live = count_i > CNT_W'(IDX);
  assign hit  = tok_q && (!live || (rem_q < delta_q));
  assign pass = tok_q && !hit;

  assign link_o.handle = handle_q;
  assign link_o.delta  = delta_q;
  assign link_o.rem    = rem_q;
  assign link_o.pass   = pass;
  assign link_o.hit    = hit;

  // next state of the slot
  always_comb begin
    handle_d = handle_q;
    delta_d  = delta_q;
    tok_d    = prev_i.pass;
    rem_d    = rem_q;
    passed_d = passed_q;
    if (prev_i.pass) begin
      rem_d = prev_i.rem - prev_i.delta;
    end
    if (cmd_i.hit_any) begin
      passed_d = 1'b0;
      if (hit) begin
        handle_d = cmd_i.new_handle;
        delta_d  = rem_q;
      end else if (!passed_q) begin
        // later entry: shift down; successor of the new entry is trimmed
        handle_d = prev_i.handle;
        delta_d  = prev_i.hit ? (prev_i.delta - prev_i.rem) : prev_i.delta;
      end
    end else if (cmd_i.pop) begin
      handle_d = next_i.handle;
      delta_d  = next_i.delta;
    end else if (cmd_i.fix && (IDX == 0)) begin
      delta_d = cmd_i.fix_delta;
    end
    if (pass) begin
      passed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      tok_q    <= tok_d;
      passed_q <= passed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    delta_q  <= delta_d;
    rem_q    <= rem_d;
  end

endmodule
